>>> sv/rca_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the range conflict admission block.
// Used by rca_cell, rca_queue and range_conflict_admission; depends on nothing.
package rca_pkg;

  localparam int ACTIVE_SLOTS_DEF = 16;
  localparam int QUEUE_SLOTS_DEF  = 16;

  localparam int CMD_W    = 2;
  localparam int TAG_W    = 8;
  localparam int START_W  = 32;
  localparam int LEN_W    = 16;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SUBMIT   = 2'd0,
    CMD_COMPLETE = 2'd1,
    CMD_RUN      = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADMITTED = 2'd0,
    ST_DEFERRED = 2'd1,
    ST_ISSUED   = 2'd2,
    ST_REJECTED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUB,
    S_CPL,
    S_RD,
    S_EV,
    S_FIN
  } state_t;

  // One page range with its tag, as held in a table cell or a queue entry.
  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic [TAG_W-1:0]   tag;
  } range_t;

  // Commands broadcast from the controller to every cell.
  typedef struct packed {
    logic wr_en;
    logic clr_en;
  } cell_ctl_t;

  // Flags rippled from cell to cell, lowest slot first.
  typedef struct packed {
    logic conflict;
    logic free_seen;
    logic match_seen;
  } chain_t;

endpackage

>>> sv/rca_cell.sv
`timescale 1ns / 1ps
// One slot of the active range table, with its link in the priority chain.
// Depends on rca_pkg.
module rca_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  rca_pkg::range_t    probe,
  input  rca_pkg::cell_ctl_t ctl,
  input  rca_pkg::chain_t    chain_in,
  output rca_pkg::chain_t    chain_out
);
  import rca_pkg::*;

  logic               valid_r;
  logic [START_W-1:0] start_r;
  logic [LEN_W-1:0]   len_r;
  logic [TAG_W-1:0]   tag_r;

  logic [START_W:0] probe_end;
  logic [START_W:0] own_end;
  logic             overlap;
  logic             chosen;
  logic             matched;

  assign probe_end = {1'b0, probe.start} + {{(START_W-LEN_W+1){1'b0}}, probe.len};
  assign own_end   = {1'b0, start_r} + {{(START_W-LEN_W+1){1'b0}}, len_r};
  assign overlap   = ({1'b0, probe.start} < own_end) && ({1'b0, start_r} < probe_end);

  // The first free slot takes a new range; the first matching slot is freed.
  assign chosen  = !valid_r && !chain_in.free_seen;
  assign matched = valid_r && (tag_r == probe.tag) && !chain_in.match_seen;

  assign chain_out.conflict   = chain_in.conflict | (valid_r & overlap);
  assign chain_out.free_seen  = chain_in.free_seen | !valid_r;
  assign chain_out.match_seen = chain_in.match_seen | matched;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.wr_en && chosen) begin
      valid_r <= 1'b1;
    end else if (ctl.clr_en && matched) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && chosen) begin
      start_r <= probe.start;
      len_r   <= probe.len;
      tag_r   <= probe.tag;
    end
  end

endmodule

>>> sv/rca_queue.sv
`timescale 1ns / 1ps
// Circular FIFO of deferred requests, held in a memory with registered read.
// Depends on rca_pkg.
module rca_queue #(
  parameter int QUEUE_SLOTS = rca_pkg::QUEUE_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push_en,
  input  rca_pkg::range_t                  push_data,
  input  logic                             pop_en,
  output rca_pkg::range_t                  rd_data,
  output logic [$clog2(QUEUE_SLOTS+1)-1:0] fill
);
  import rca_pkg::*;

  localparam int PW = $clog2(QUEUE_SLOTS);
  localparam int CW = $clog2(QUEUE_SLOTS + 1);

  range_t          mem [QUEUE_SLOTS];
  range_t          rd_data_r;
  logic [PW-1:0]   head_r, head_nxt;
  logic [PW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (pop_en) begin
      head_nxt = (head_r == PW'(QUEUE_SLOTS - 1)) ? '0 : head_r + 1'b1;
    end
    if (push_en) begin
      tail_nxt = (tail_r == PW'(QUEUE_SLOTS - 1)) ? '0 : tail_r + 1'b1;
    end
    count_nxt = count_r + CW'(push_en) - CW'(pop_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[tail_r] <= push_data;
    end
    if (pop_en) begin
      rd_data_r <= mem[head_r];
    end
  end

  assign rd_data = rd_data_r;
  assign fill    = count_r;

endmodule

>>> sv/range_conflict_admission.sv
`timescale 1ns / 1ps
// Top level of the range conflict admission block: controller, cell row and queue.
// Depends on rca_pkg, rca_cell and rca_queue.

// A word is taken when start is high and busy is low. A submit or a complete
// keeps the block busy while it is handled, so no new word is taken until
// the block is back in S_IDLE. A run walks the deferred queue one entry at a
// time (reading the queue memory in S_RD, then testing the entry against the
// cell row in S_EV), then flushes its final result in S_FIN. A run leaves at
// once, going back to idle with no result, when the deferred queue is
// empty. Results appear on out_id, out_status and out_last for exactly one
// cycle, marked by out_valid, and cannot be held off by the receiver; at most
// one result is produced per cycle. A submit gives exactly one result, a
// complete none, and a run one result per issued entry, with out_last set on
// the final one. The conflict test against every active range is done by a
// row of identical cells, each holding one table slot; free-slot and
// tag-match priority ripple along the row from the lowest slot upwards.
module range_conflict_admission #(
  parameter int ACTIVE_SLOTS = rca_pkg::ACTIVE_SLOTS_DEF,
  parameter int QUEUE_SLOTS  = rca_pkg::QUEUE_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [rca_pkg::CMD_W-1:0]    in_command,
  input  logic [rca_pkg::TAG_W-1:0]    in_req_id,
  input  logic [rca_pkg::START_W-1:0]  in_start_page,
  input  logic [rca_pkg::LEN_W-1:0]    in_page_count,
  output logic                         out_valid,
  output logic [rca_pkg::TAG_W-1:0]    out_id,
  output logic [rca_pkg::STATUS_W-1:0] out_status,
  output logic                         out_last
);
  import rca_pkg::*;

  localparam int CW = $clog2(QUEUE_SLOTS + 1);

  state_t        state_r, state_nxt;
  range_t        req_r;
  logic [CW-1:0] rem_r, rem_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [TAG_W-1:0] pend_id_r, pend_id_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [TAG_W-1:0] out_id_r, out_id_nxt;
  status_t       out_status_r, out_status_nxt;
  logic          out_last_r, out_last_nxt;

  range_t        probe;
  cell_ctl_t     ctl;
  chain_t        chain [ACTIVE_SLOTS+1];

  logic          push_en;
  range_t        push_data;
  logic          pop_en;
  range_t        q_data;
  logic [CW-1:0] fill;
  logic          q_full;
  logic          fits;

  // The row of table cells; the chain enters at slot zero with nothing seen.
  assign chain[0] = '0;

  for (genvar i = 0; i < ACTIVE_SLOTS; i++) begin : g_cell
    rca_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .probe     (probe),
      .ctl       (ctl),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  rca_queue #(
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (push_en),
    .push_data (push_data),
    .pop_en    (pop_en),
    .rd_data   (q_data),
    .fill      (fill)
  );

  // While a run evaluates, the cells are probed with the entry just read from
  // the queue; otherwise with the accepted word.
  assign probe  = (state_r == S_EV) ? q_data : req_r;
  assign q_full = (fill == CW'(QUEUE_SLOTS));
  assign fits   = !chain[ACTIVE_SLOTS].conflict && chain[ACTIVE_SLOTS].free_seen;
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    rem_nxt        = rem_r;
    pend_v_nxt     = pend_v_r;
    pend_id_nxt    = pend_id_r;
    out_valid_nxt  = 1'b0;
    out_id_nxt     = out_id_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    ctl            = '0;
    push_en        = 1'b0;
    push_data      = probe;
    pop_en         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_command)
            CMD_SUBMIT:   state_nxt = S_SUB;
            CMD_COMPLETE: state_nxt = S_CPL;
            CMD_RUN: begin
              rem_nxt   = fill;
              state_nxt = (fill == '0) ? S_IDLE : S_RD;
            end
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_SUB: begin
        out_valid_nxt = 1'b1;
        out_id_nxt    = req_r.tag;
        out_last_nxt  = 1'b1;
        if (fits) begin
          ctl.wr_en      = 1'b1;
          out_status_nxt = ST_ADMITTED;
        end else if (!q_full) begin
          push_en        = 1'b1;
          out_status_nxt = ST_DEFERRED;
        end else begin
          out_status_nxt = ST_REJECTED;
        end
        state_nxt = S_IDLE;
      end
      S_CPL: begin
        ctl.clr_en = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_RD: begin
        pop_en    = 1'b1;
        rem_nxt   = rem_r - 1'b1;
        state_nxt = S_EV;
      end
      S_EV: begin
        if (fits) begin
          // An issued entry is held back until the next one issues or the walk
          // ends, so that the last one of the walk can be flagged.
          ctl.wr_en = 1'b1;
          if (pend_v_r) begin
            out_valid_nxt  = 1'b1;
            out_id_nxt     = pend_id_r;
            out_status_nxt = ST_ISSUED;
            out_last_nxt   = 1'b0;
          end
          pend_v_nxt  = 1'b1;
          pend_id_nxt = q_data.tag;
        end else begin
          push_en = 1'b1;
        end
        state_nxt = (rem_r == '0) ? S_FIN : S_RD;
      end
      S_FIN: begin
        if (pend_v_r) begin
          out_valid_nxt  = 1'b1;
          out_id_nxt     = pend_id_r;
          out_status_nxt = ST_ISSUED;
          out_last_nxt   = 1'b1;
        end
        pend_v_nxt = 1'b0;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r    <= pend_id_nxt;
    out_id_r     <= out_id_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    if (start && !busy) begin
      req_r.start <= in_start_page;
      req_r.len   <= in_page_count;
      req_r.tag   <= in_req_id;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_id     = out_id_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  // A range is only written into the table when it clears every active range.
  a_write_fits : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr_en |-> fits)
    else $error("table write without a free, conflict-free slot");

  // The queue is never pushed beyond its capacity.
  a_push_room : assert property (@(posedge clk) disable iff (!rst_n)
    push_en |-> (fill < CW'(QUEUE_SLOTS) || pop_en))
    else $error("push into a full queue");

  // A submit result always closes its word.
  a_submit_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_ISSUED) |-> out_last)
    else $error("submit result without last flag");

  // The held-back issued entry is always flushed at the end of a run.
  a_flush : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> !pend_v_r)
    else $error("pending issued entry left after a run");

  // Results only follow work that the controller was doing.
  a_out_origin : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_SUB || $past(state_r) == S_EV ||
                   $past(state_r) == S_FIN))
    else $error("result strobe without a source");

endmodule
